>>> rtl/tla_pkg.sv
// Shared types and constants for the text line assembler.
package tla_pkg;

   // Line buffer geometry
   localparam int LINE_CAPACITY = 512;
   localparam int ADDR_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
   localparam int FILL_W = $clog2(LINE_CAPACITY + 1);

   // Queue between front and back (power of two)
   localparam int FQ_DEPTH = 2;
   localparam int FQ_PTR_W = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
   localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

   // Result queue (power of two)
   localparam int OQ_DEPTH = 4;
   localparam int OQ_PTR_W = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;
   localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

   // Byte codes
   localparam logic [7:0] LF_BYTE   = 8'h0A;
   localparam logic [7:0] CR_BYTE   = 8'h0D;
   localparam logic [7:0] CTRL_LAST = 8'h1F;
   localparam logic [7:0] DEL_BYTE  = 8'h7F;

   // Statistics counter slots
   localparam int NUM_STATS = 6;
   localparam int ST_TOTAL  = 0;
   localparam int ST_EMPTY  = 1;
   localparam int ST_TRUNC  = 2;
   localparam int ST_CR     = 3;
   localparam int ST_CTRL   = 4;
   localparam int ST_OVF    = 5;

   typedef enum logic [1:0] {
      CMD_FEED    = 2'd0,
      CMD_READ    = 2'd1,
      CMD_CONSUME = 2'd2,
      CMD_RESET   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CLS_LF,
      CLS_CR,
      CLS_CTRL,
      CLS_DATA
   } byte_class_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] byte_value;
      logic [8:0] char_index;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic        line_ready;
      logic        line_truncated;
      logic [9:0]  line_length;
      logic [7:0]  read_char;
      logic [31:0] total_lines;
      logic [31:0] empty_lines;
      logic [31:0] truncated_lines;
      logic [31:0] cr_drops;
      logic [31:0] control_drops;
      logic [31:0] overflow_drops;
   } rsp_type;

   // Classified item handed from front to back
   typedef struct packed {
      cmd_type        cmd;
      byte_class_type cls;
      logic [7:0]     byte_value;
      logic [8:0]     char_index;
   } work_type;

   typedef struct packed {
      logic [OQ_CNT_W-1:0] count;
   } oq_status_type;

endpackage

>>> rtl/tla_front.sv
// Front end: takes request items, classifies the byte and queues the work.
module tla_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  tla_pkg::req_type    req_data,
   input  logic                work_pop,
   output logic                work_valid,
   output tla_pkg::work_type   work_data
);

   tla_pkg::work_type                  entry_ff [tla_pkg::FQ_DEPTH];
   logic [tla_pkg::FQ_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [tla_pkg::FQ_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [tla_pkg::FQ_CNT_W-1:0]       count_ff, count_in;
   tla_pkg::work_type                  classified;
   logic                               push;
   logic                               pop;

   always_comb begin
      classified.cmd        = tla_pkg::cmd_type'(req_data.command);
      classified.byte_value = req_data.byte_value;
      classified.char_index = req_data.char_index;
      case (req_data.byte_value) inside
         tla_pkg::LF_BYTE:                    classified.cls = tla_pkg::CLS_LF;
         tla_pkg::CR_BYTE:                    classified.cls = tla_pkg::CLS_CR;
         [8'h00:tla_pkg::CTRL_LAST],
         tla_pkg::DEL_BYTE:                   classified.cls = tla_pkg::CLS_CTRL;
         default:                             classified.cls = tla_pkg::CLS_DATA;
      endcase
   end

   assign req_full   = (count_ff == tla_pkg::FQ_CNT_W'(tla_pkg::FQ_DEPTH));
   assign work_valid = (count_ff != '0);
   assign work_data  = entry_ff[rd_ptr_ff];
   assign push       = req_push && !req_full;
   assign pop        = work_pop && work_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

>>> rtl/tla_back.sv
// Back end: line state, line buffer, statistics and result assembly.
module tla_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    work_valid,
   input  tla_pkg::work_type       work_data,
   output logic                    work_pop,
   input  tla_pkg::oq_status_type  oq_status,
   output logic                    rsp_push,
   output tla_pkg::rsp_type        rsp_item
);

   // Line buffer
   logic [7:0]                    line_mem [tla_pkg::LINE_CAPACITY];
   logic [7:0]                    mem_rd_ff;
   logic                          mem_we;
   logic [tla_pkg::ADDR_W-1:0]    mem_waddr;
   logic [tla_pkg::ADDR_W-1:0]    mem_raddr;

   // Line state
   logic [tla_pkg::FILL_W-1:0]    fill_ff, fill_in;
   logic                          ready_ff, ready_in;
   logic                          trunc_ff, trunc_in;
   logic                          ovf_ff, ovf_in;
   logic [31:0]                   stat_ff [tla_pkg::NUM_STATS];
   logic [tla_pkg::NUM_STATS-1:0] bump;

   // Result stage
   logic                          s2_valid_ff;
   tla_pkg::rsp_type              s2_rsp_ff, s2_rsp_in;
   logic                          s2_hit_ff, s2_hit_in;

   logic                          accepted;
   logic                          go;
   logic [tla_pkg::OQ_CNT_W:0]    slots_used;
   logic [31:0]                   idx_ext;
   logic [31:0]                   fill_ext;
   logic [31:0]                   len_ext;

   // Only issue when the result queue is sure to have room for it
   assign slots_used = {1'b0, oq_status.count} + (tla_pkg::OQ_CNT_W + 1)'(s2_valid_ff);
   assign go         = work_valid && (slots_used < (tla_pkg::OQ_CNT_W + 1)'(tla_pkg::OQ_DEPTH));
   assign work_pop   = go;

   assign idx_ext   = 32'(work_data.char_index);
   assign fill_ext  = 32'(fill_ff);
   assign mem_raddr = idx_ext[tla_pkg::ADDR_W-1:0];
   assign mem_waddr = fill_ff[tla_pkg::ADDR_W-1:0];

   always_comb begin
      fill_in   = fill_ff;
      ready_in  = ready_ff;
      trunc_in  = trunc_ff;
      ovf_in    = ovf_ff;
      bump      = '0;
      accepted  = 1'b0;
      mem_we    = 1'b0;
      s2_hit_in = 1'b0;
      if (go) begin
         case (work_data.cmd)
            tla_pkg::CMD_FEED: begin
               if (!ready_ff) begin
                  accepted = 1'b1;
                  case (work_data.cls)
                     tla_pkg::CLS_LF: begin
                        if (fill_ff == '0) begin
                           bump[tla_pkg::ST_EMPTY] = 1'b1;
                        end else begin
                           trunc_in                = ovf_ff;
                           ovf_in                  = 1'b0;
                           ready_in                = 1'b1;
                           bump[tla_pkg::ST_TOTAL] = 1'b1;
                           bump[tla_pkg::ST_TRUNC] = ovf_ff;
                        end
                     end
                     tla_pkg::CLS_CR:   bump[tla_pkg::ST_CR]   = 1'b1;
                     tla_pkg::CLS_CTRL: bump[tla_pkg::ST_CTRL] = 1'b1;
                     default: begin
                        if (ovf_ff) begin
                           bump[tla_pkg::ST_OVF] = 1'b1;
                        end else if (fill_ext >= tla_pkg::LINE_CAPACITY) begin
                           ovf_in                = 1'b1;
                           bump[tla_pkg::ST_OVF] = 1'b1;
                        end else begin
                           mem_we  = 1'b1;
                           fill_in = fill_ff + 1'b1;
                        end
                     end
                  endcase
               end
            end
            tla_pkg::CMD_READ: begin
               s2_hit_in = ready_ff && (idx_ext < fill_ext)
                           && (idx_ext < tla_pkg::LINE_CAPACITY);
            end
            tla_pkg::CMD_CONSUME: begin
               if (ready_ff) begin
                  fill_in  = '0;
                  ready_in = 1'b0;
                  trunc_in = 1'b0;
               end
            end
            default: begin
               fill_in  = '0;
               ready_in = 1'b0;
               trunc_in = 1'b0;
               ovf_in   = 1'b0;
            end
         endcase
      end
   end

   // Result fields show the state after the item; counters after their bump
   assign len_ext = 32'(fill_in);

   always_comb begin
      s2_rsp_in.accepted        = accepted;
      s2_rsp_in.line_ready      = ready_in;
      s2_rsp_in.line_truncated  = ready_in && trunc_in;
      s2_rsp_in.line_length     = ready_in ? len_ext[9:0] : 10'd0;
      s2_rsp_in.read_char       = 8'd0;
      s2_rsp_in.total_lines     = stat_ff[tla_pkg::ST_TOTAL]
                                  + 32'(bump[tla_pkg::ST_TOTAL]);
      s2_rsp_in.empty_lines     = stat_ff[tla_pkg::ST_EMPTY]
                                  + 32'(bump[tla_pkg::ST_EMPTY]);
      s2_rsp_in.truncated_lines = stat_ff[tla_pkg::ST_TRUNC]
                                  + 32'(bump[tla_pkg::ST_TRUNC]);
      s2_rsp_in.cr_drops        = stat_ff[tla_pkg::ST_CR]
                                  + 32'(bump[tla_pkg::ST_CR]);
      s2_rsp_in.control_drops   = stat_ff[tla_pkg::ST_CTRL]
                                  + 32'(bump[tla_pkg::ST_CTRL]);
      s2_rsp_in.overflow_drops  = stat_ff[tla_pkg::ST_OVF]
                                  + 32'(bump[tla_pkg::ST_OVF]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         ready_ff    <= 1'b0;
         trunc_ff    <= 1'b0;
         ovf_ff      <= 1'b0;
         s2_valid_ff <= 1'b0;
         for (int k = 0; k < tla_pkg::NUM_STATS; k++) begin
            stat_ff[k] <= '0;
         end
      end else begin
         fill_ff     <= fill_in;
         ready_ff    <= ready_in;
         trunc_ff    <= trunc_in;
         ovf_ff      <= ovf_in;
         s2_valid_ff <= go;
         for (int k = 0; k < tla_pkg::NUM_STATS; k++) begin
            stat_ff[k] <= stat_ff[k] + 32'(bump[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      s2_rsp_ff <= s2_rsp_in;
      s2_hit_ff <= s2_hit_in;
   end

   // Buffer: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[mem_waddr] <= work_data.byte_value;
      end
      mem_rd_ff <= line_mem[mem_raddr];
   end

   always_comb begin
      rsp_item           = s2_rsp_ff;
      rsp_item.read_char = s2_hit_ff ? mem_rd_ff : 8'd0;
   end

   assign rsp_push = s2_valid_ff;

endmodule

>>> rtl/tla_out_queue.sv
// Result queue feeding the response port.
module tla_out_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  tla_pkg::rsp_type        push_data,
   input  logic                    rsp_pop,
   output logic                    rsp_empty,
   output tla_pkg::rsp_type        rsp_data,
   output tla_pkg::oq_status_type  status
);

   tla_pkg::rsp_type               entry_ff [tla_pkg::OQ_DEPTH];
   logic [tla_pkg::OQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [tla_pkg::OQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [tla_pkg::OQ_CNT_W-1:0]   count_ff, count_in;
   logic                           pop;

   assign rsp_empty    = (count_ff == '0);
   assign rsp_data     = entry_ff[rd_ptr_ff];
   assign status.count = count_ff;
   assign pop          = rsp_pop && !rsp_empty;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/text_line_assembler_core.sv
// Top level of the text line assembler: front end, back end and result queue.
//
//   channel   dir   handshake          payload
//   req_      in    req_push/req_full  req_data  (command, byte_value, char_index)
//   rsp_      out   rsp_empty/rsp_pop  rsp_data  (flags, length, char, six counters)
//
// One item per cycle while the result queue has room, set by the execute step (one buffer
// write or read a cycle); results pass the execute register, then the result queue.
// Reset is synchronous and clears line state, counters and both queues at once;
// the line buffer is not cleared, as only written entries are ever read.
// req_full rises only when the two-entry front queue is full, which happens when
// the result queue backs up with rsp_pop held low.
module text_line_assembler_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  tla_pkg::req_type  req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output tla_pkg::rsp_type  rsp_data
);

   logic                    work_valid;
   logic                    work_pop;
   tla_pkg::work_type       work_data;
   tla_pkg::oq_status_type  oq_status;
   logic                    rsp_push;
   tla_pkg::rsp_type        rsp_item;

   // Front: byte classification and the short queue to the back end
   tla_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .work_pop   (work_pop),
      .work_valid (work_valid),
      .work_data  (work_data)
   );

   // Back: line state, buffer, statistics; only issues when a result slot is free
   tla_back u_back (
      .clock      (clock),
      .reset      (reset),
      .work_valid (work_valid),
      .work_data  (work_data),
      .work_pop   (work_pop),
      .oq_status  (oq_status),
      .rsp_push   (rsp_push),
      .rsp_item   (rsp_item)
   );

   // Results wait here so the back end keeps going while rsp_pop is low, until the queue fills
   tla_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_item),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .status    (oq_status)
   );

   // Credit scheme must never let the result queue run over
   a_oq_bound: assert property (@(posedge clock) disable iff (reset)
      oq_status.count <= tla_pkg::OQ_CNT_W'(tla_pkg::OQ_DEPTH))
      else $error("result queue over capacity");

   // No held line means no length and no truncation mark
   a_len_ready: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.line_ready) |->
         (rsp_data.line_length == 10'd0 && !rsp_data.line_truncated))
      else $error("length or truncation shown without a held line");

   // A character can only be read out of a held line
   a_char_ready: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.read_char != 8'd0) |-> rsp_data.line_ready)
      else $error("character returned with no line held");

   // Both queues come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

endmodule
